// File: rtl/core/ggfg_pkg.sv
// shared types, widths and constants for the generalized gaussian face gradient
// no dependencies
package ggfg_pkg;

  // build-time shape of the profile
  localparam int SHAPE_EXPONENT = 2;
  localparam int EXP_TABLE_BITS = 8;

  // datapath widths
  localparam int MAG_W = 33;             // |face - centre|
  localparam int U_W   = 23;             // scaled axis distance, capped at 64.0
  localparam int S_W   = 46;             // sum of squares, Q14.32
  localparam int R_W   = 23;             // radius, Q7.16
  localparam int T_W   = 22;             // r^n, capped at 32.0
  localparam int K_W   = 7;              // integer part of t*log2(e)
  localparam int M_W   = 33;             // mantissa, Q0.32 with room for 1.0
  localparam int G_W   = 17;             // exp(-t), Q1.16 in [0, 1.0]
  localparam int P_W   = 34;             // offset plus gain term
  localparam int PL_W  = 51;             // p times a distance half
  localparam int V_W   = 52;             // unsaturated result

  localparam logic [U_W-1:0] U_CAP     = U_W'(64 << 16);
  localparam logic [T_W-1:0] T_CAP     = T_W'(32 << 16);
  localparam logic [16:0]    LOG2E_Q16 = 17'd94548;

  // configuration register map
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_PEAK_GAIN   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_BASE_OFFSET = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CENTRE_X    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CENTRE_Y    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CENTRE_Z    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_INV_WIDTH_X = 3'd5;
  localparam logic [CFG_AW-1:0] REG_INV_WIDTH_Y = 3'd6;
  localparam logic [CFG_AW-1:0] REG_INV_WIDTH_Z = 3'd7;

  typedef struct packed {
    logic signed [31:0] peak_gain;
    logic signed [31:0] base_offset;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic [31:0]        inv_width_x;
    logic [31:0]        inv_width_y;
    logic [31:0]        inv_width_z;
  } cfg_t;

  // fields that ride along the pipeline untouched until the final stages
  typedef struct packed {
    logic signed [31:0] cell_value;
    logic [31:0]        face_distance;
  } side_t;

  // floor square root, elaboration use only
  function automatic longint unsigned isqrt_c(longint unsigned val);
    longint unsigned v;
    longint unsigned res;
    longint unsigned bitv;
    v    = val;
    res  = 0;
    bitv = 64'h4000_0000_0000_0000;
    for (int n = 0; n < 32; n++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-j) in Q0.32
  function automatic logic [31:0] exp_coef(int j);
    longint unsigned c;
    c = isqrt_c(64'h8000_0000_0000_0000);
    for (int n = 2; n <= j; n++) begin
      c = isqrt_c(c << 32);
    end
    return 32'(c);
  endfunction

endpackage

// File: rtl/core/generalized_gaussian_face_gradient.sv
// top level of the generalized gaussian face gradient: registers and pipeline
// depends on ggfg_pkg, ggfg_front, ggfg_isqrt, ggfg_exp, ggfg_out
//
// usage
//   one face per input word on the s_axis side; one result word per face on
//   the m_axis side, in order. the result is
//   cell_value + face_distance * (base_offset + peak_gain * exp(-r^n)),
//   with r the radius scaled per axis by the inverse widths, saturated to
//   32 bits; m_axis_tuser flags a clipped result
//   configuration is a plain write port (cfg_we_i, cfg_addr_i, cfg_wdata_i),
//   one register per index, written while no face is in flight
// timing
//   a face passes the front, square root, exp and output stages in turn from
//   acceptance to m_axis_tvalid; most of the path is the square root, which
//   settles one bit of the radius per stage
//   throughput is one word per cycle while the output register is empty or taken
// reset and stall
//   reset empties the pipeline and loads the register defaults (gain 1.0,
//   inverse widths 1.0, centre and offset zero)
//   while the output register holds a word that is not taken, the whole
//   pipeline freezes and s_axis_tready drops; nothing is lost or repeated
module generalized_gaussian_face_gradient import ggfg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // face_x, face_y, face_z, cell_value, face_distance (32 bits each, lowest first)
  input  logic [159:0]      s_axis_tdata,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // face_value
  output logic [31:0]       m_axis_tdata,
  // saturated
  output logic              m_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [31:0]       cfg_wdata_i
);

  cfg_t cfg_q;
  logic en;

  // the pipeline moves whenever the output register is empty or being taken
  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_gain   <= 32'sd65536;
      cfg_q.base_offset <= '0;
      cfg_q.centre_x    <= '0;
      cfg_q.centre_y    <= '0;
      cfg_q.centre_z    <= '0;
      cfg_q.inv_width_x <= 32'd65536;
      cfg_q.inv_width_y <= 32'd65536;
      cfg_q.inv_width_z <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PEAK_GAIN:   cfg_q.peak_gain   <= cfg_wdata_i;
        REG_BASE_OFFSET: cfg_q.base_offset <= cfg_wdata_i;
        REG_CENTRE_X:    cfg_q.centre_x    <= cfg_wdata_i;
        REG_CENTRE_Y:    cfg_q.centre_y    <= cfg_wdata_i;
        REG_CENTRE_Z:    cfg_q.centre_z    <= cfg_wdata_i;
        REG_INV_WIDTH_X: cfg_q.inv_width_x <= cfg_wdata_i;
        REG_INV_WIDTH_Y: cfg_q.inv_width_y <= cfg_wdata_i;
        REG_INV_WIDTH_Z: cfg_q.inv_width_z <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // cell value and distance ride along until the output stages
  side_t side_in;
  assign side_in.cell_value    = s_axis_tdata[127:96];
  assign side_in.face_distance = s_axis_tdata[159:128];

  logic           fr_valid;
  logic [S_W-1:0] fr_sum;
  side_t          fr_side;

  ggfg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .face_x_i (s_axis_tdata[31:0]),
    .face_y_i (s_axis_tdata[63:32]),
    .face_z_i (s_axis_tdata[95:64]),
    .side_i   (side_in),
    .cfg_i    (cfg_q),
    .valid_o  (fr_valid),
    .sum_o    (fr_sum),
    .side_o   (fr_side)
  );

  logic           sq_valid;
  logic [R_W-1:0] sq_root;
  side_t          sq_side;

  ggfg_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .sum_i   (fr_sum),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  logic           ex_valid;
  logic [G_W-1:0] ex_gauss;
  side_t          ex_side;

  ggfg_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .side_i  (sq_side),
    .valid_o (ex_valid),
    .gauss_o (ex_gauss),
    .side_o  (ex_side)
  );

  ggfg_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (ex_valid),
    .gauss_i      (ex_gauss),
    .side_i       (ex_side),
    .cfg_i        (cfg_q),
    .valid_o      (m_axis_tvalid),
    .face_value_o (m_axis_tdata),
    .saturated_o  (m_axis_tuser)
  );

endmodule

// File: rtl/core/ggfg_front.sv
// axis offset, scaling and sum of squares, four stages
// depends on ggfg_pkg
module ggfg_front import ggfg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] face_x_i,
  input  logic signed [31:0] face_y_i,
  input  logic signed [31:0] face_z_i,
  input  side_t              side_i,
  input  cfg_t               cfg_i,
  output logic               valid_o,
  output logic [S_W-1:0]     sum_o,
  output side_t              side_o
);

  logic signed [31:0] face   [3];
  logic signed [31:0] centre [3];
  logic [31:0]        inv    [3];

  logic [MAG_W-1:0] mag_d [3];
  logic [MAG_W-1:0] mag_q [3];
  logic [U_W-1:0]   u_d   [3];
  logic [U_W-1:0]   u_q   [3];
  logic [S_W-1:0]   sq_q  [3];
  logic [S_W-1:0]   sum_q;
  logic [3:0]       v_q;
  side_t            side_q [4];

  assign face[0]   = face_x_i;
  assign face[1]   = face_y_i;
  assign face[2]   = face_z_i;
  assign centre[0] = cfg_i.centre_x;
  assign centre[1] = cfg_i.centre_y;
  assign centre[2] = cfg_i.centre_z;
  assign inv[0]    = cfg_i.inv_width_x;
  assign inv[1]    = cfg_i.inv_width_y;
  assign inv[2]    = cfg_i.inv_width_z;

  always_comb begin
    logic signed [MAG_W-1:0] diff;
    logic [64:0]             prod;
    for (int a = 0; a < 3; a++) begin
      diff     = MAG_W'(face[a]) - MAG_W'(centre[a]);
      mag_d[a] = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      prod     = 65'(mag_q[a]) * 65'(inv[a]);
      u_d[a]   = (prod[64:16] > 49'(U_CAP)) ? U_CAP : prod[16+U_W-1:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        mag_q[a] <= mag_d[a];
        u_q[a]   <= u_d[a];
        sq_q[a]  <= S_W'(u_q[a]) * S_W'(u_q[a]);
      end
      sum_q     <= sq_q[0] + sq_q[1] + sq_q[2];
      side_q[0] <= side_i;
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];
      side_q[3] <= side_q[2];
    end
  end

  assign valid_o = v_q[3];
  assign sum_o   = sum_q;
  assign side_o  = side_q[3];

endmodule

// File: rtl/core/ggfg_isqrt.sv
// pipelined floor square root, one result bit per stage
// depends on ggfg_pkg
module ggfg_isqrt import ggfg_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [S_W-1:0] sum_i,
  input  side_t          side_i,
  output logic           valid_o,
  output logic [R_W-1:0] root_o,
  output side_t          side_o
);

  localparam int REM_W = R_W + 2;

  logic [REM_W-1:0] rem_q  [R_W];
  logic [R_W-1:0]   root_q [R_W];
  logic [S_W-1:0]   rad_q  [R_W];
  logic [R_W-1:0]   v_q;
  side_t            side_q [R_W];

  for (genvar i = 0; i < R_W; i++) begin : g_step
    logic [REM_W-1:0] rem_in;
    logic [R_W-1:0]   root_in;
    logic [S_W-1:0]   rad_in;
    side_t            side_in;
    logic             v_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sum_i;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign side_in = side_q[i-1];
      assign v_in    = v_q[i-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[S_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= {rad_in[S_W-3:0], 2'b00};
        side_q[i] <= side_in;
        if (rem_sh >= trial) begin
          rem_q[i]  <= rem_sh - trial;
          root_q[i] <= {root_in[R_W-2:0], 1'b1};
        end else begin
          rem_q[i]  <= rem_sh;
          root_q[i] <= {root_in[R_W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[R_W-1];
  assign root_o  = root_q[R_W-1];
  assign side_o  = side_q[R_W-1];

endmodule

// File: rtl/core/ggfg_exp.sv
// radius power and exp(-t) by base-2 reduction with a table of roots of one half
// depends on ggfg_pkg
module ggfg_exp import ggfg_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [R_W-1:0] root_i,
  input  side_t          side_i,
  output logic           valid_o,
  output logic [G_W-1:0] gauss_o,
  output side_t          side_o
);

  localparam int SE = SHAPE_EXPONENT;
  localparam int TB = EXP_TABLE_BITS;

  // power stages
  logic [T_W-1:0] t_q    [SE];
  logic [R_W-1:0] r_q    [SE];
  logic [SE-1:0]  pv_q;
  side_t          pside_q [SE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q[0] <= 1'b0;
    end else if (en_i) begin
      pv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0]     <= (root_i > R_W'(T_CAP)) ? T_CAP : root_i[T_W-1:0];
      r_q[0]     <= root_i;
      pside_q[0] <= side_i;
    end
  end

  for (genvar p = 1; p < SE; p++) begin : g_pow
    logic [T_W+R_W-1:0] prod;
    assign prod = (T_W+R_W)'(t_q[p-1]) * (T_W+R_W)'(r_q[p-1]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[p] <= 1'b0;
      end else if (en_i) begin
        pv_q[p] <= pv_q[p-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[p]     <= (prod[T_W+R_W-1:16] > (T_W+R_W-16)'(T_CAP)) ? T_CAP
                      : prod[16+T_W-1:16];
        r_q[p]     <= r_q[p-1];
        pside_q[p] <= pside_q[p-1];
      end
    end
  end

  // t * log2(e), split into integer and table index; mantissa stages follow
  logic [T_W+16:0] y_prod;
  logic [M_W-1:0]  m_q    [TB+1];
  logic [K_W-1:0]  k_q    [TB+1];
  logic [TB-1:0]   f_q    [TB+1];
  logic [TB:0]     mv_q;
  side_t           mside_q [TB+1];

  assign y_prod = (T_W+17)'(t_q[SE-1]) * (T_W+17)'(LOG2E_Q16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q[0] <= 1'b0;
    end else if (en_i) begin
      mv_q[0] <= pv_q[SE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]     <= M_W'(1) << 32;
      k_q[0]     <= y_prod[32+K_W-1:32];
      f_q[0]     <= y_prod[31 -: TB];
      mside_q[0] <= pside_q[SE-1];
    end
  end

  for (genvar j = 1; j <= TB; j++) begin : g_mant
    localparam logic [31:0] COEF = exp_coef(j);
    logic [M_W+31:0] prod;
    assign prod = (M_W+32)'(m_q[j-1]) * (M_W+32)'(COEF);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[j] <= 1'b0;
      end else if (en_i) begin
        mv_q[j] <= mv_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[j]     <= f_q[j-1][TB-j] ? prod[32+M_W-1:32] : m_q[j-1];
        k_q[j]     <= k_q[j-1];
        f_q[j]     <= f_q[j-1];
        mside_q[j] <= mside_q[j-1];
      end
    end
  end

  // final scale by 2^-(16+k)
  logic           gv_q;
  logic [G_W-1:0] g_q;
  side_t          gside_q;
  logic [M_W-1:0] m_shift;

  assign m_shift = m_q[TB] >> (K_W'(16) + k_q[TB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gv_q <= 1'b0;
    end else if (en_i) begin
      gv_q <= mv_q[TB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_q     <= (k_q[TB] > K_W'(16)) ? '0 : m_shift[G_W-1:0];
      gside_q <= mside_q[TB];
    end
  end

  assign valid_o = gv_q;
  assign gauss_o = g_q;
  assign side_o  = gside_q;

endmodule

// File: rtl/core/ggfg_out.sv
// gain, offset, distance scaling, saturation and the output register
// depends on ggfg_pkg
module ggfg_out import ggfg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [G_W-1:0]     gauss_i,
  input  side_t              side_i,
  input  cfg_t               cfg_i,
  output logic               valid_o,
  output logic signed [31:0] face_value_o,
  output logic               saturated_o
);

  logic [4:0]              v_q;
  logic signed [49:0]      pg_q;
  logic signed [P_W-1:0]   p_q  [2];
  logic signed [PL_W-1:0]  plo_q [2];
  logic signed [PL_W-1:0]  phi_q;
  logic signed [V_W-1:0]   sum_q;
  side_t                   side_q [4];
  logic                    out_v_q;
  logic signed [31:0]      out_q;
  logic                    sat_q;

  logic signed [G_W:0]     g_s;
  logic signed [16:0]      dlo_s;
  logic signed [16:0]      dhi_s;

  assign g_s   = {1'b0, gauss_i};
  assign dlo_s = {1'b0, side_q[1].face_distance[15:0]};
  assign dhi_s = {1'b0, side_q[2].face_distance[31:16]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[3:0], valid_i};
      out_v_q <= v_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pg_q      <= cfg_i.peak_gain * g_s;
      side_q[0] <= side_i;
      p_q[0]    <= P_W'(pg_q >>> 16) + P_W'(cfg_i.base_offset);
      side_q[1] <= side_q[0];
      plo_q[0]  <= p_q[0] * dlo_s;
      p_q[1]    <= p_q[0];
      side_q[2] <= side_q[1];
      phi_q     <= p_q[1] * dhi_s;
      plo_q[1]  <= plo_q[0];
      side_q[3] <= side_q[2];
      sum_q     <= V_W'(side_q[3].cell_value) + V_W'(phi_q) + V_W'(plo_q[1] >>> 16);
      if (sum_q > 52'sd2147483647) begin
        out_q <= 32'sh7fff_ffff;
        sat_q <= 1'b1;
      end else if (sum_q < -52'sd2147483648) begin
        out_q <= 32'sh8000_0000;
        sat_q <= 1'b1;
      end else begin
        out_q <= sum_q[31:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign valid_o      = out_v_q;
  assign face_value_o = out_q;
  assign saturated_o  = sat_q;

endmodule

// File: rtl/core/ggfg_check.sv
// port-level checks for the generalized gaussian face gradient, bound to the top
// depends on ggfg_pkg
module ggfg_check import ggfg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready,
  input logic [31:0]       m_axis_tdata,
  input logic              m_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // a clipped result sits on one of the two limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata == 32'h7fff_ffff || m_axis_tdata == 32'h8000_0000)
    else $error("saturated flag without a limit value");

  // an accepting receiver never blocks the input side
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

endmodule

bind generalized_gaussian_face_gradient ggfg_check u_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
